@@ design/fpcd_pkg.sv @@
package fpcd_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int PAGE_BITS_DEF = 32;

  // Request kinds carried on s_tuser; the fourth code is dropped.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // Configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_BACKING  = 1'b1;

  localparam int CFG_W  = 5;
  localparam int OUT_W  = 104;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT,
    ST_FILL,
    ST_EVICT,
    ST_FLUSH_SCAN,
    ST_FLUSH_WB,
    ST_FLUSH_NONE
  } state_t;

endpackage

@@ design/fifo_page_cache_directory_core.sv @@
// Page cache directory, fully associative, FIFO replacement, write-back.
//
// Requests arrive as beats on the s_ channel: s_tuser carries the kind
// (read, write, flush) and s_tdata the page number. Each read or write gives
// one result beat on the m_ channel: hit flag, slot, fetch request and, when
// a dirty entry is evicted, the write-back request with the victim page,
// plus the running hit and miss counts. A flush gives one beat per dirty
// slot in ascending order, or a single empty beat if none is dirty or the
// backing store is detached; m_tlast marks the final beat of each request.
//
// One request is in flight at a time. Page tags live in a single-port memory
// read one entry a cycle, so a read or write compares the filled tags in
// turn and a flush scans the slots in turn, with a write-back for each dirty
// one. The fourth request kind is dropped without a beat. A finished beat
// waits in the output register and the next request is taken meanwhile; a
// new beat is held back only while that register is occupied.
// Reset clears the directory (fill count, FIFO pointer, dirty bits), the
// counters and m_tvalid; capacity returns to 16 (clamped to SLOTS) and the
// backing store to attached. Tag memory contents are not reset.
module fifo_page_cache_directory_core #(
  parameter int SLOTS     = fpcd_pkg::SLOTS_DEF,
  parameter int PAGE_BITS = fpcd_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [fpcd_pkg::CFG_W-1:0] cfg_data,
  // request channel
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // [31:0] page_number
  input  logic [1:0]                 s_tuser,   // [1:0] operation
  // result channel
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [0] hit, [4:1] slot, [5] fetch, [6] writeback, [38:7] victim_page,
  // [70:39] hit_count, [102:71] miss_count, [103] zero
  output logic [fpcd_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);

  import fpcd_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int CW     = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  // configuration
  logic [CFG_W-1:0]     capacity;
  logic                 backing;

  // directory state
  logic [PAGE_BITS-1:0] tag_mem [SLOTS];
  logic [PAGE_BITS-1:0] rd_data;
  logic [SLOTS-1:0]     dirty;
  logic [FILL_W-1:0]    fill_count;
  logic [SLOT_W-1:0]    oldest;
  logic [31:0]          hits_total;
  logic [31:0]          misses_total;

  // request in flight
  state_t               state, state_next;
  logic [1:0]           op;
  logic [PAGE_BITS-1:0] page;
  logic [SLOT_W-1:0]    idx;

  // derived control
  logic [FILL_W-1:0]    cap_eff;
  logic [CW-1:0]        cap_wide;
  logic [CW-1:0]        idx_inc;
  logic                 more_tags;
  logic                 tag_match;
  logic                 room;
  logic [SLOT_W-1:0]    victim_slot;
  logic [SLOT_W-1:0]    victim_after;
  logic                 dirty_above;
  logic                 out_free;
  logic                 accept;
  logic [PAGE_BITS+31:0] page_in_ext;
  logic [PAGE_BITS+31:0] victim_ext;
  logic [SLOT_W+3:0]    slot_ext;

  // memory control and result fields
  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  logic                 emit;
  logic                 r_hit;
  logic                 r_fetch;
  logic                 r_wb;
  logic                 r_last;
  logic [31:0]          r_victim;
  logic [31:0]          r_hits;
  logic [31:0]          r_misses;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Clamp capacity to 1..SLOTS.
  always_comb begin
    cap_wide = CW'(capacity);
    if (cap_wide == '0) begin
      cap_wide = CW'(1);
    end else if (cap_wide > CW'(SLOTS)) begin
      cap_wide = CW'(SLOTS);
    end
    cap_eff = FILL_W'(cap_wide);
  end

  assign idx_inc   = CW'(idx) + CW'(1);
  assign more_tags = idx_inc < CW'(fill_count);
  assign tag_match = (rd_data == page);
  assign room      = fill_count < cap_eff;

  // Oldest slot wraps to zero once it lies beyond a lowered capacity.
  always_comb begin
    victim_slot = oldest;
    if (CW'(oldest) >= CW'(cap_eff)) begin
      victim_slot = '0;
    end
    victim_after = SLOT_W'(CW'(victim_slot) + CW'(1));
    if (CW'(victim_slot) + CW'(1) >= CW'(cap_eff)) begin
      victim_after = '0;
    end
  end

  always_comb begin
    dirty_above = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (dirty[j] && (CW'(j) > CW'(idx))) begin
        dirty_above = 1'b1;
      end
    end
  end

  assign page_in_ext = {{PAGE_BITS{1'b0}}, s_tdata};
  assign victim_ext  = {32'd0, rd_data};
  assign slot_ext    = {4'd0, idx};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_READ || s_tuser == OP_WRITE) begin
            state_next = (fill_count == '0) ? ST_FILL : ST_SEARCH;
          end else if (s_tuser == OP_FLUSH) begin
            state_next = (backing && (|dirty)) ? ST_FLUSH_SCAN : ST_FLUSH_NONE;
          end
        end
      end
      ST_SEARCH: begin
        if (tag_match) begin
          state_next = ST_HIT;
        end else if (!more_tags) begin
          state_next = room ? ST_FILL : ST_EVICT;
        end
      end
      ST_HIT, ST_FILL, ST_EVICT, ST_FLUSH_NONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH_SCAN: begin
        if (dirty[idx]) begin
          state_next = ST_FLUSH_WB;
        end
      end
      ST_FLUSH_WB: begin
        if (out_free) begin
          state_next = dirty_above ? ST_FLUSH_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake, memory control, result fields
  always_comb begin
    s_tready = (state == ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx;
    emit     = 1'b0;
    r_hit    = 1'b0;
    r_fetch  = 1'b0;
    r_wb     = 1'b0;
    r_last   = 1'b1;
    r_victim = '0;
    r_hits   = hits_total;
    r_misses = misses_total;
    case (state)
      ST_IDLE: begin
        rd_en = accept;
      end
      ST_SEARCH: begin
        if (!tag_match) begin
          if (more_tags) begin
            rd_en   = 1'b1;
            rd_addr = SLOT_W'(idx_inc);
          end else if (!room) begin
            rd_en   = 1'b1;
            rd_addr = victim_slot;
          end
        end
      end
      ST_HIT: begin
        emit   = out_free;
        r_hit  = 1'b1;
        r_hits = hits_total + 32'd1;
      end
      ST_FILL: begin
        emit     = out_free;
        wr_en    = out_free;
        wr_addr  = SLOT_W'(fill_count);
        r_fetch  = 1'b1;
        r_misses = misses_total + 32'd1;
      end
      ST_EVICT: begin
        emit     = out_free;
        wr_en    = out_free;
        r_fetch  = 1'b1;
        r_wb     = dirty[idx];
        r_victim = dirty[idx] ? victim_ext[31:0] : 32'd0;
        r_misses = misses_total + 32'd1;
      end
      ST_FLUSH_SCAN: begin
        rd_en   = dirty[idx];
        rd_addr = idx;
      end
      ST_FLUSH_WB: begin
        emit     = out_free;
        r_wb     = 1'b1;
        r_victim = victim_ext[31:0];
        r_last   = !dirty_above;
      end
      ST_FLUSH_NONE: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // tag memory: one port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= page;
    end
    if (rd_en) begin
      rd_data <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CFG_W'(16);
      backing  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data;
        CFG_BACKING:  backing  <= cfg_data[0];
        default:      backing  <= backing;
      endcase
    end
  end

  // request registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= s_tuser;
      page <= page_in_ext[PAGE_BITS-1:0];
      idx  <= '0;
    end else begin
      case (state)
        ST_SEARCH: begin
          if (!tag_match && more_tags) begin
            idx <= SLOT_W'(idx_inc);
          end else if (!tag_match && !room) begin
            idx <= victim_slot;
          end else if (!tag_match) begin
            // point at the free slot that the fill takes
            idx <= SLOT_W'(fill_count);
          end
        end
        ST_FLUSH_SCAN: begin
          if (!dirty[idx]) begin
            idx <= SLOT_W'(idx_inc);
          end
        end
        ST_FLUSH_WB: begin
          if (out_free) begin
            idx <= SLOT_W'(idx_inc);
          end
        end
        default: idx <= idx;
      endcase
    end
  end

  // directory bookkeeping and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty        <= '0;
      fill_count   <= '0;
      oldest       <= '0;
      hits_total   <= '0;
      misses_total <= '0;
    end else if (out_free) begin
      case (state)
        ST_HIT: begin
          hits_total <= hits_total + 32'd1;
          if (op == OP_WRITE) begin
            dirty[idx] <= 1'b1;
          end
        end
        ST_FILL: begin
          misses_total                  <= misses_total + 32'd1;
          dirty[SLOT_W'(fill_count)]    <= (op == OP_WRITE);
          fill_count                    <= fill_count + FILL_W'(1);
        end
        ST_EVICT: begin
          misses_total <= misses_total + 32'd1;
          dirty[idx]   <= (op == OP_WRITE);
          oldest       <= victim_after;
        end
        ST_FLUSH_WB: begin
          if (!dirty_above) begin
            dirty      <= '0;
            fill_count <= '0;
            oldest     <= '0;
          end
        end
        ST_FLUSH_NONE: begin
          dirty      <= '0;
          fill_count <= '0;
          oldest     <= '0;
        end
        default: begin
          fill_count <= fill_count;
        end
      endcase
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0, r_misses, r_hits, r_victim, r_wb, r_fetch, slot_ext[3:0], r_hit};
      m_tlast <= r_last;
    end
  end

endmodule
